// ===== rtl/mrq_pkg.sv =====
// Shared types, codes and defaults of the multilevel ready queue.
package mrq_pkg;

   // Field widths fixed by the command and result formats.
   localparam int CMD_W    = 2;
   localparam int PRIO_W   = 8;
   localparam int TASK_W   = 4;
   localparam int STATUS_W = 3;
   localparam int OFFSET_W = 8;

   // Defaults handed to the top-level parameters.
   localparam int TASK_COUNT_DEFAULT  = 16;
   localparam int LEVEL_COUNT_DEFAULT = 4;

   // Level offset after reset.
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd128;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_POP        = 2'd3
   } command_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_BAD_PRIO = 3'd3,
      ST_DUP      = 3'd4
   } status_type;

   // One request beat.
   typedef struct packed {
      command_type         command;
      logic [PRIO_W-1:0]   priority_req;
      logic [TASK_W-1:0]   task_id;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [TASK_W-1:0]   picked_task;
      status_type          status;
   } rsp_type;

endpackage

// ===== rtl/multilevel_ready_queue_core.sv =====
// Multilevel ready queue: per-level FIFOs of task ids kept as doubly linked lists.
// Sequence: S_IDLE takes the request beat, a pop of a nonempty level reads its head in S_READ,
// S_CHECK writes the task's entry, S_NBR_A and S_NBR_B patch up to two neighbors, S_FIN loads
// the result beat. The single read port of the link memory sets this sequence.
// A request is taken only after the last result is loaded; a stalled result beat holds the next.
// Reset empties every level and marks every task as not queued; offset returns to 128.
module multilevel_ready_queue_core #(
   parameter int TASK_COUNT  = mrq_pkg::TASK_COUNT_DEFAULT,
   parameter int LEVEL_COUNT = mrq_pkg::LEVEL_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mrq_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mrq_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mrq_pkg::OFFSET_W-1:0]  csr_data
);
   import mrq_pkg::*;

   localparam int TID_W   = $clog2(TASK_COUNT);
   localparam int LINK_W  = $clog2(TASK_COUNT + 1);
   localparam int LV_W    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int MARK_W  = $clog2(LEVEL_COUNT + 1);
   localparam int ENTRY_W = 2 * LINK_W + MARK_W;
   localparam int CMP_W   = TASK_W + TID_W + 1;
   localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(TASK_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_NBR_A,
      S_NBR_B,
      S_FIN
   } state_type;

   // Pending read-modify-write of one neighbor's link.
   typedef struct packed {
      logic [TID_W-1:0]  addr;
      logic              set_next;
      logic [LINK_W-1:0] value;
   } patch_type;

   state_type           state_ff, state_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [TID_W-1:0]    head_ff [LEVEL_COUNT];
   logic [TID_W-1:0]    head_in [LEVEL_COUNT];
   logic [TID_W-1:0]    tail_ff [LEVEL_COUNT];
   logic [TID_W-1:0]    tail_in [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] busy_ff, busy_in;
   logic [TASK_COUNT-1:0]  written_ff, written_in;
   command_type         cmd_ff, cmd_in;
   logic [LV_W-1:0]     lv_ff, lv_in;
   logic [TID_W-1:0]    addr_ff, addr_in;
   logic                bad_ff, bad_in;
   logic                none_ff, none_in;
   patch_type           patch_a_ff, patch_a_in;
   patch_type           patch_b_ff, patch_b_in;
   logic                patch_b_en_ff, patch_b_en_in;
   logic [TID_W-1:0]    res_task_ff, res_task_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Link memory port signals.
   logic                ram_wr_en;
   logic [TID_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [TID_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [LINK_W-1:0]   rd_next;
   logic [LINK_W-1:0]   rd_prev;
   logic [MARK_W-1:0]   rd_mark;
   logic [MARK_W-1:0]   mark_eff;
   logic [MARK_W-1:0]   lv_mark;
   logic [LINK_W-1:0]   self_link;
   patch_type           patch_cur;
   logic [ENTRY_W-1:0]  patched;

   // Request decode.
   logic [PRIO_W:0]        diff;
   logic [LV_W-1:0]        req_lv;
   logic                   lv_bad;
   logic                   tid_bad;
   logic [TID_W+TASK_W-1:0] tid_wide;
   logic [TID_W-1:0]       req_addr;
   logic [TID_W+TASK_W-1:0] pick_wide;
   logic                   pop_found;
   logic [LV_W-1:0]        pop_lv;
   logic                   p_ok;
   logic                   n_ok;

   mrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TASK_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Level and range check of the incoming request.
   assign diff     = {1'b0, req_payload.priority_req} - {1'b0, offset_ff};
   assign req_lv   = diff[LV_W-1:0];
   assign lv_bad   = diff[PRIO_W] || (diff[PRIO_W-1:0] >= PRIO_W'(LEVEL_COUNT));
   assign tid_bad  = CMP_W'(req_payload.task_id) >= CMP_W'(TASK_COUNT);
   assign tid_wide = {{TID_W{1'b0}}, req_payload.task_id};
   assign req_addr = tid_wide[TID_W-1:0];

   // First nonempty level, lowest index wins.
   always_comb begin
      pop_found = 1'b0;
      pop_lv    = '0;
      for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
         if (busy_ff[i]) begin
            pop_found = 1'b1;
            pop_lv    = LV_W'(i);
         end
      end
   end

   // Fields of the word just read; a never-written entry counts as not queued.
   assign rd_next   = ram_rd_data[ENTRY_W-1 -: LINK_W];
   assign rd_prev   = ram_rd_data[MARK_W+LINK_W-1 -: LINK_W];
   assign rd_mark   = ram_rd_data[MARK_W-1:0];
   assign mark_eff  = written_ff[addr_ff] ? rd_mark : '0;
   assign lv_mark   = MARK_W'(lv_ff) + MARK_W'(1);
   assign self_link = LINK_W'(addr_ff);
   assign p_ok      = rd_prev != NO_LINK;
   assign n_ok      = rd_next != NO_LINK;

   // Neighbor word with one link replaced.
   assign patch_cur = (state_ff == S_NBR_B) ? patch_b_ff : patch_a_ff;
   assign patched   = patch_cur.set_next ? {patch_cur.value, rd_prev, rd_mark}
                                         : {rd_next, patch_cur.value, rd_mark};

   // Sequencer: decode, read the task, update the task and up to two neighbors.
   always_comb begin
      state_in      = state_ff;
      offset_in     = offset_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      busy_in       = busy_ff;
      written_in    = written_ff;
      cmd_in        = cmd_ff;
      lv_in         = lv_ff;
      addr_in       = addr_ff;
      bad_in        = bad_ff;
      none_in       = none_ff;
      patch_a_in    = patch_a_ff;
      patch_b_in    = patch_b_ff;
      patch_b_en_in = patch_b_en_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;
      pick_wide     = {{TASK_W{1'b0}}, res_task_ff};

      if (csr_valid) begin
         offset_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload.command;
               if (req_payload.command == CMD_POP) begin
                  lv_in    = pop_lv;
                  bad_in   = 1'b0;
                  none_in  = !pop_found;
                  state_in = pop_found ? S_READ : S_CHECK;
               end else begin
                  lv_in       = req_lv;
                  addr_in     = req_addr;
                  bad_in      = lv_bad || tid_bad;
                  none_in     = 1'b0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_addr;
                  state_in    = S_CHECK;
               end
            end
         end

         // A pop reads the head entry of the chosen level.
         S_READ: begin
            addr_in     = head_ff[lv_ff];
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_ff[lv_ff];
            state_in    = S_CHECK;
         end

         S_CHECK: begin
            res_task_in   = '0;
            patch_b_en_in = 1'b0;
            state_in      = S_FIN;
            if (bad_ff) begin
               res_status_in = ST_BAD_PRIO;
            end else if (cmd_ff == CMD_POP && none_ff) begin
               res_status_in = ST_EMPTY;
            end else if (cmd_ff == CMD_REMOVE && mark_eff != lv_mark) begin
               res_status_in = ST_ABSENT;
            end else if ((cmd_ff == CMD_PUSH_BACK || cmd_ff == CMD_PUSH_FRONT)
                         && mark_eff != '0) begin
               res_status_in = ST_DUP;
            end else if (cmd_ff == CMD_PUSH_BACK || cmd_ff == CMD_PUSH_FRONT) begin
               res_status_in = ST_OK;
               ram_wr_en     = 1'b1;
               ram_wr_addr   = addr_ff;
               if (!busy_ff[lv_ff]) begin
                  // First task of an empty level.
                  ram_wr_data    = {NO_LINK, NO_LINK, lv_mark};
                  head_in[lv_ff] = addr_ff;
                  tail_in[lv_ff] = addr_ff;
                  busy_in[lv_ff] = 1'b1;
               end else if (cmd_ff == CMD_PUSH_BACK) begin
                  ram_wr_data    = {NO_LINK, LINK_W'(tail_ff[lv_ff]), lv_mark};
                  patch_a_in     = '{addr: tail_ff[lv_ff], set_next: 1'b1, value: self_link};
                  tail_in[lv_ff] = addr_ff;
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = tail_ff[lv_ff];
                  state_in       = S_NBR_A;
               end else begin
                  ram_wr_data    = {LINK_W'(head_ff[lv_ff]), NO_LINK, lv_mark};
                  patch_a_in     = '{addr: head_ff[lv_ff], set_next: 1'b0, value: self_link};
                  head_in[lv_ff] = addr_ff;
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = head_ff[lv_ff];
                  state_in       = S_NBR_A;
               end
            end else begin
               // Remove or pop: clear the task and splice its neighbors together.
               res_status_in = ST_OK;
               res_task_in   = addr_ff;
               ram_wr_en     = 1'b1;
               ram_wr_addr   = addr_ff;
               ram_wr_data   = {NO_LINK, NO_LINK, {MARK_W{1'b0}}};
               if (p_ok) begin
                  patch_a_in    = '{addr: rd_prev[TID_W-1:0], set_next: 1'b1, value: rd_next};
                  patch_b_in    = '{addr: rd_next[TID_W-1:0], set_next: 1'b0, value: rd_prev};
                  patch_b_en_in = n_ok;
                  ram_rd_en     = 1'b1;
                  ram_rd_addr   = rd_prev[TID_W-1:0];
                  state_in      = S_NBR_A;
                  if (!n_ok) begin
                     tail_in[lv_ff] = rd_prev[TID_W-1:0];
                  end
               end else if (n_ok) begin
                  head_in[lv_ff] = rd_next[TID_W-1:0];
                  patch_a_in     = '{addr: rd_next[TID_W-1:0], set_next: 1'b0, value: NO_LINK};
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = rd_next[TID_W-1:0];
                  state_in       = S_NBR_A;
               end else begin
                  busy_in[lv_ff] = 1'b0;
               end
            end
         end

         // First neighbor: write back the patched word, start the second read if there is one.
         S_NBR_A: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = patch_a_ff.addr;
            ram_wr_data = patched;
            if (patch_b_en_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = patch_b_ff.addr;
               state_in    = S_NBR_B;
            end else begin
               state_in = S_FIN;
            end
         end

         S_NBR_B: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = patch_b_ff.addr;
            ram_wr_data = patched;
            state_in    = S_FIN;
         end

         // Load the result beat once the output register is free.
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.picked_task = pick_wide[TASK_W-1:0];
               rsp_data_in.status      = res_status_ff;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_wr_en) begin
         written_in[ram_wr_addr] = 1'b1;
      end
   end

   // State, level table, valid bits and output register.
   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      cmd_ff        <= cmd_in;
      lv_ff         <= lv_in;
      addr_ff       <= addr_in;
      bad_ff        <= bad_in;
      none_ff       <= none_in;
      patch_a_ff    <= patch_a_in;
      patch_b_ff    <= patch_b_in;
      patch_b_en_ff <= patch_b_en_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         offset_ff    <= OFFSET_RESET;
         busy_ff      <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         busy_ff      <= busy_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready   = 1'b1;

endmodule

// ===== rtl/mrq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read at the written address returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mrq_checker.sv =====
// Port-level checks of the multilevel ready queue, bound to its top level.
module mrq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mrq_pkg::rsp_type  rsp_payload
);
   import mrq_pkg::*;

   // Reset leaves no result beat and an open request side.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("queue not idle after reset");

   // An accepted request keeps the block busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after an accepted beat");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // Any answer other than success carries the null task.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.picked_task == '0)
      else $error("refused request returned a task");

endmodule

bind multilevel_ready_queue_core mrq_checker u_mrq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== verif/multilevel_ready_queue_core_tb.sv =====
// Self-checking testbench for the multilevel ready queue core.
`timescale 1ns / 100ps

module multilevel_ready_queue_core_tb;
   import mrq_pkg::*;

   localparam int TASKS          = TASK_COUNT_DEFAULT;
   localparam int LEVELS         = LEVEL_COUNT_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_payload;
   logic                csr_valid;
   logic                csr_ready;
   logic [OFFSET_W-1:0] csr_data;

   // Shadow copy of the ready queue: one FIFO per level plus each task's level mark.
   logic [OFFSET_W-1:0] offset_shadow = OFFSET_RESET;
   logic [TASK_W-1:0]   level_fifo [LEVELS][$];
   logic [2:0]          queued_level [TASKS];

   // Result beats predicted but not yet seen, oldest first.
   rsp_type expected_rsp [$];

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp_req = 1'b0;

   multilevel_ready_queue_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Apply one command to the shadow queue and return the result it should give.
   function automatic rsp_type predict_queue(input req_type r);
      rsp_type o;
      int      lvl;
      int      idx;
      int      i;
      bit      found;
      o.picked_task = '0;
      o.status      = ST_OK;
      found         = 1'b0;
      if (r.command == CMD_POP) begin
         o.status = ST_EMPTY;
         for (i = 0; i < LEVELS; i++) begin
            if (!found && level_fifo[i].size() != 0) begin
               o.picked_task = level_fifo[i].pop_front();
               queued_level[o.picked_task] = '0;
               o.status = ST_OK;
               found = 1'b1;
            end
         end
      end else begin
         lvl = int'(r.priority_req) - int'(offset_shadow);
         if (lvl < 0 || lvl >= LEVELS || int'(r.task_id) >= TASKS) begin
            o.status = ST_BAD_PRIO;
         end else if (r.command == CMD_REMOVE) begin
            if (int'(queued_level[r.task_id]) != lvl + 1) begin
               o.status = ST_ABSENT;
            end else begin
               idx = 0;
               for (i = 0; i < level_fifo[lvl].size(); i++) begin
                  if (level_fifo[lvl][i] == r.task_id) idx = i;
               end
               level_fifo[lvl].delete(idx);
               queued_level[r.task_id] = '0;
               o.picked_task = r.task_id;
            end
         end else if (queued_level[r.task_id] != '0) begin
            o.status = ST_DUP;
         end else begin
            if (r.command == CMD_PUSH_BACK) begin
               level_fifo[lvl].push_back(r.task_id);
            end else begin
               level_fifo[lvl].push_front(r.task_id);
            end
            queued_level[r.task_id] = 3'(lvl + 1);
         end
      end
      return o;
   endfunction

   // Predict on every accepted request beat and compare every accepted result beat.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) offset_shadow = csr_data;
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_queue(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result beat: picked_task %0d, status %0d",
                      rsp_payload.picked_task, rsp_payload.status);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.picked_task !== want.picked_task) begin
                  $error("picked_task: expected %0d, actual %0d",
                         want.picked_task, rsp_payload.picked_task);
                  errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("multilevel_ready_queue_core: mismatch");
         $finish;
      end
   end

   // Result side: random stall runs, plus one long hold-off when a test asks for it.
   initial begin : rsp_drive
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one request beat after a random gap and wait until it is taken.
   task automatic send_cmd(input command_type c, input logic [PRIO_W-1:0] p,
                           input logic [TASK_W-1:0] t);
      int      gap;
      req_type r;
      gap            = pick_gap();
      r.command      = c;
      r.priority_req = p;
      r.task_id      = t;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic drain_queue();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OFFSET_W-1:0] v);
      drain_queue();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly legal commands at reachable levels, removes aimed at queued tasks, some noise.
   task automatic send_random_cmd();
      int                  roll;
      int                  top;
      int                  n_queued;
      int                  ins_weight;
      int                  i;
      command_type         c;
      logic [PRIO_W-1:0]   p;
      logic [TASK_W-1:0]   t;
      n_queued = 0;
      for (i = 0; i < TASKS; i++) begin
         if (queued_level[i] != '0) n_queued++;
      end
      top = (255 - int'(offset_shadow) < LEVELS - 1) ? 255 - int'(offset_shadow) : LEVELS - 1;
      t = TASK_W'($urandom_range(0, TASKS - 1));
      p = offset_shadow + PRIO_W'($urandom_range(0, top));
      ins_weight = (n_queued < 12) ? 45 : 20;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         c = command_type'(CMD_W'($urandom_range(0, 3)));
         p = PRIO_W'($urandom_range(0, 255));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < ins_weight) begin
            c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         end else if (roll < ins_weight + 25) begin
            c = CMD_POP;
         end else begin
            c = CMD_REMOVE;
            if (queued_level[t] != '0 && $urandom_range(0, 3) != 0) begin
               p = offset_shadow + PRIO_W'(queued_level[t] - 3'd1);
            end
         end
      end
      send_cmd(c, p, t);
   endtask

   // Empty pops, refused priorities, duplicates, absent removes, task 0 queued.
   task automatic test_directed_basics();
      send_cmd(CMD_POP,        8'd0,   4'd0);
      send_cmd(CMD_REMOVE,     8'd128, 4'd3);
      send_cmd(CMD_PUSH_BACK,  8'd127, 4'd1);
      send_cmd(CMD_PUSH_FRONT, 8'd132, 4'd1);
      send_cmd(CMD_PUSH_BACK,  8'd255, 4'd15);
      send_cmd(CMD_PUSH_BACK,  8'd0,   4'd0);
      send_cmd(CMD_PUSH_BACK,  8'd128, 4'd0);
      send_cmd(CMD_PUSH_FRONT, 8'd131, 4'd15);
      send_cmd(CMD_PUSH_BACK,  8'd130, 4'd0);
      send_cmd(CMD_PUSH_BACK,  8'd128, 4'd5);
      send_cmd(CMD_PUSH_FRONT, 8'd128, 4'd9);
      send_cmd(CMD_REMOVE,     8'd129, 4'd5);
      send_cmd(CMD_REMOVE,     8'd128, 4'd0);
      send_cmd(CMD_POP,        8'd255, 4'd15);
      send_cmd(CMD_POP,        8'd0,   4'd0);
      send_cmd(CMD_POP,        8'd0,   4'd0);
      send_cmd(CMD_POP,        8'd0,   4'd0);
   endtask

   // Lowest and highest offsets, including the level just past the last one.
   task automatic test_offset_extremes();
      write_offset(8'd0);
      send_cmd(CMD_PUSH_BACK,  8'd0,   4'd7);
      send_cmd(CMD_PUSH_BACK,  8'd3,   4'd8);
      send_cmd(CMD_PUSH_BACK,  8'd4,   4'd1);
      send_cmd(CMD_REMOVE,     8'd3,   4'd8);
      send_cmd(CMD_POP,        8'd0,   4'd0);
      write_offset(8'd255);
      send_cmd(CMD_PUSH_FRONT, 8'd255, 4'd2);
      send_cmd(CMD_PUSH_BACK,  8'd254, 4'd3);
      send_cmd(CMD_POP,        8'd0,   4'd0);
   endtask

   // Random traffic over several offsets, one phase without any idling.
   task automatic test_random_traffic();
      logic [OFFSET_W-1:0] offsets [6];
      int                  ph;
      int                  k;
      offsets = '{8'd128, 8'd0, 8'd255, 8'd252, 8'd0, 8'd0};
      offsets[4] = OFFSET_W'($urandom_range(0, 255));
      offsets[5] = OFFSET_W'($urandom_range(0, 255));
      for (ph = 0; ph < 6; ph++) begin
         write_offset(offsets[ph]);
         idle_on = (ph != 2);
         for (k = 0; k < 300; k++) send_random_cmd();
      end
      idle_on = 1'b1;
   endtask

   // Long result hold-off while requests keep coming, so the block backs up.
   task automatic test_back_pressure();
      int k;
      write_offset(8'd64);
      hold_rsp_req = 1'b1;
      for (k = 0; k < 30; k++) send_random_cmd();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      for (int i = 0; i < TASKS; i++) queued_level[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_offset_extremes();
      test_random_traffic();
      test_back_pressure();

      drain_queue();
      repeat (8) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("multilevel_ready_queue_core: match");
      end else begin
         $display("multilevel_ready_queue_core: mismatch");
      end
      $finish;
   end

endmodule
